[rtl/csma_rtc_pkg.sv]
// shared types and constants of the csma retry transmit controller
package csma_rtc_pkg;

  localparam int TimerBitsDef = 24;   // default countdown width
  localparam int CfgIdxW      = 3;    // configuration register index width
  localparam int CfgDataW     = 16;   // widest configuration register
  localparam int ProdW        = 20;   // backoff units times unit ticks

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLinkEn     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRadioCaps  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMinBe      = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMaxBe      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgUnitTicks  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgAckTicks   = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgCsmaOffEnd = 3'd6;

  // radio capability bits
  localparam int CapAckTimeout = 0;
  localparam int CapRetries    = 1;
  localparam int CapCsma       = 2;

  localparam logic [3:0] BeLimit = 4'd8;
  localparam logic [3:0] CntMax  = 4'd15;

  typedef enum logic [1:0] {
    REQ_TRANSMIT = 2'd0,
    REQ_STARTED  = 2'd1,
    REQ_DONE     = 2'd2,
    REQ_TICK     = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ACT_NONE   = 2'd0,
    ACT_START  = 2'd1,
    ACT_REPORT = 2'd2,
    ACT_REJECT = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_ACK = 2'd1,
    ST_CAF    = 2'd2,
    ST_ABORT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PURP_NONE  = 2'd0,
    PURP_ACK   = 2'd1,
    PURP_CSMA  = 2'd2,
    PURP_STRAY = 2'd3
  } purpose_e;

  // radio status codes on the input side
  localparam logic [2:0] RstOk    = 3'd0;
  localparam logic [2:0] RstNoAck = 3'd1;
  localparam logic [2:0] RstCaf   = 3'd2;
  localparam logic [2:0] RstAbort = 3'd3;

  typedef struct packed {
    logic        link_enabled;
    logic [2:0]  radio_offload;
    logic [3:0]  min_be;
    logic [3:0]  max_be;
    logic [11:0] backoff_unit_ticks;
    logic [15:0] ack_timeout_ticks;
    logic        csma_off_last_try;
  } cfg_t;

  typedef struct packed {
    req_type_e  req_type;
    logic [3:0] max_backoffs;
    logic [3:0] max_retries;
    logic       ack_requested;
    logic [2:0] radio_status;
    logic [7:0] random_draw;
  } item_t;

  typedef struct packed {
    logic    valid;
    action_e action;
    status_e done_status;
    logic    use_csma;
    logic    resume_receive;
  } result_t;

endpackage

[rtl/csma_retry_transmit_controller_top.sv]
// top level of the csma retry transmit controller: ports, config, item and result registers
// Event-driven transmit controller with unslotted csma-ca backoff, frame
// retries and ack timeout, each done here only where radio_offload says the
// radio does not do it. Every event (transmit request, transmit started,
// radio result, timer tick) is one transaction on the slave stream with the
// event kind in tuser; it yields zero or one result transaction on the master
// stream with the action in tuser. One transaction is taken per clock: an
// accepted item sits in the input register, and the step logic (backoff
// exponent, one 8x12 multiply, counter and timer updates) runs between
// that register and the result register, which holds the result. The step
// is held only while a result waits in the output register and the master
// side is stalled. Configuration writes are taken at once and must only
// happen while the block is idle.
module csma_retry_transmit_controller_top #(
  parameter int TIMER_BITS = csma_rtc_pkg::TimerBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [csma_rtc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [csma_rtc_pkg::CfgDataW-1:0]  cfg_data_i,
  // event stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [3:0] max_backoffs, [7:4] max_retries, [8] ack_requested,
  // [11:9] radio_status, [19:12] random_draw, [23:20] zero
  input  logic [23:0]                        s_axis_tdata,
  // [1:0] req_type
  input  logic [1:0]                         s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [1:0] done_status, [2] use_csma, [3] resume_receive, [7:4] zero
  output logic [7:0]                         m_axis_tdata,
  // [1:0] action
  output logic [1:0]                         m_axis_tuser
);

  csma_rtc_pkg::cfg_t    cfg_q;
  csma_rtc_pkg::item_t   item_q;
  csma_rtc_pkg::result_t res;
  logic                  in_valid_q;
  logic                  out_valid_q;
  csma_rtc_pkg::action_e out_action_q;
  csma_rtc_pkg::status_e out_status_q;
  logic                  out_csma_q;
  logic                  out_resume_q;
  logic                  step;

  // step runs when the result register is free or being emptied
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.link_enabled       <= 1'b0;
      cfg_q.radio_offload      <= 3'd0;
      cfg_q.min_be             <= 4'd3;
      cfg_q.max_be             <= 4'd5;
      cfg_q.backoff_unit_ticks <= 12'd320;
      cfg_q.ack_timeout_ticks  <= 16'd16000;
      cfg_q.csma_off_last_try  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        csma_rtc_pkg::CfgLinkEn:     cfg_q.link_enabled       <= cfg_data_i[0];
        csma_rtc_pkg::CfgRadioCaps:  cfg_q.radio_offload      <= cfg_data_i[2:0];
        csma_rtc_pkg::CfgMinBe:      cfg_q.min_be             <= cfg_data_i[3:0];
        csma_rtc_pkg::CfgMaxBe:      cfg_q.max_be             <= cfg_data_i[3:0];
        csma_rtc_pkg::CfgUnitTicks:  cfg_q.backoff_unit_ticks <= cfg_data_i[11:0];
        csma_rtc_pkg::CfgAckTicks:   cfg_q.ack_timeout_ticks  <= cfg_data_i[15:0];
        csma_rtc_pkg::CfgCsmaOffEnd: cfg_q.csma_off_last_try  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.req_type      <= csma_rtc_pkg::req_type_e'(s_axis_tuser);
      item_q.max_backoffs  <= s_axis_tdata[3:0];
      item_q.max_retries   <= s_axis_tdata[7:4];
      item_q.ack_requested <= s_axis_tdata[8];
      item_q.radio_status  <= s_axis_tdata[11:9];
      item_q.random_draw   <= s_axis_tdata[19:12];
    end
  end

  csma_rtc_core #(
    .TIMER_BITS(TIMER_BITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .step_i  (step),
    .item_i  (item_q),
    .result_o(res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.valid;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_action_q <= res.action;
      out_status_q <= res.done_status;
      out_csma_q   <= res.use_csma;
      out_resume_q <= res.resume_receive;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_action_q;
  assign m_axis_tdata  = {4'b0000, out_resume_q, out_csma_q, out_status_q};

endmodule

[rtl/csma_rtc_backoff.sv]
// csma backoff length: exponent, random mask, unit multiply and saturation
module csma_rtc_backoff #(
  parameter int TIMER_BITS = csma_rtc_pkg::TimerBitsDef
) (
  input  logic [3:0]            min_be_i,
  input  logic [3:0]            max_be_i,
  input  logic [11:0]           unit_ticks_i,
  input  logic [3:0]            retry_count_i,
  input  logic [3:0]            backoff_count_i,
  input  logic [7:0]            random_draw_i,
  output logic [TIMER_BITS-1:0] ticks_o
);

  localparam int ExtW = (TIMER_BITS > csma_rtc_pkg::ProdW) ? TIMER_BITS
                                                            : csma_rtc_pkg::ProdW;
  localparam logic [TIMER_BITS-1:0] TimerMax = '1;

  logic [5:0]                    be_sum;
  logic [3:0]                    be_cap;
  logic [3:0]                    be;
  logic [7:0]                    mask;
  logic [7:0]                    units;
  logic [csma_rtc_pkg::ProdW-1:0] prod;
  logic [ExtW-1:0]               prod_ext;

  always_comb begin
    be_sum   = {2'b00, min_be_i} + {2'b00, retry_count_i} + {2'b00, backoff_count_i};
    be_cap   = (be_sum > {2'b00, max_be_i}) ? max_be_i : be_sum[3:0];
    be       = (be_cap > csma_rtc_pkg::BeLimit) ? csma_rtc_pkg::BeLimit : be_cap;
    mask     = 8'((9'd1 << be) - 9'd1);
    units    = random_draw_i & mask;
    prod     = csma_rtc_pkg::ProdW'(units) * csma_rtc_pkg::ProdW'(unit_ticks_i);
    prod_ext = ExtW'(prod);
    // saturate at the largest countdown
    ticks_o  = (prod_ext > ExtW'(TimerMax)) ? TimerMax : TIMER_BITS'(prod_ext);
  end

endmodule

[rtl/csma_rtc_core.sv]
// controller state and the per-event step: counters, timer and result
module csma_rtc_core #(
  parameter int TIMER_BITS = csma_rtc_pkg::TimerBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  csma_rtc_pkg::cfg_t    cfg_i,
  input  logic                 step_i,
  input  csma_rtc_pkg::item_t   item_i,
  output csma_rtc_pkg::result_t result_o
);

  logic [3:0] rc_q, rc_d, bc_q, bc_d, fmb_q, fmb_d, fmr_q, fmr_d;
  logic       csma_q, csma_d;
  logic [TIMER_BITS-1:0]  cnt_q, cnt_d, cnt_a, cnt_dec, bo_ticks;
  csma_rtc_pkg::purpose_e purp_q, purp_d, purp_a;
  csma_rtc_pkg::action_e  act_a, act;
  csma_rtc_pkg::status_e  st;
  logic       resume, go_start, do_done, restart;
  logic [2:0] err;

  // counters and decision
  always_comb begin
    rc_d     = rc_q;
    bc_d     = bc_q;
    fmb_d    = fmb_q;
    fmr_d    = fmr_q;
    csma_d   = csma_q;
    cnt_a    = cnt_q;
    purp_a   = purp_q;
    act_a    = csma_rtc_pkg::ACT_NONE;
    st       = csma_rtc_pkg::ST_OK;
    resume   = 1'b0;
    go_start = 1'b0;
    do_done  = 1'b0;
    restart  = 1'b0;
    err      = csma_rtc_pkg::RstOk;
    cnt_dec  = (cnt_q == '0) ? '0 : cnt_q - TIMER_BITS'(1);
    if (step_i) begin
      case (item_i.req_type)
        csma_rtc_pkg::REQ_TRANSMIT: begin
          if (!cfg_i.link_enabled) begin
            act_a = csma_rtc_pkg::ACT_REJECT;
          end else begin
            fmb_d  = item_i.max_backoffs;
            fmr_d  = item_i.max_retries;
            csma_d = 1'b1;
            if (!cfg_i.radio_offload[csma_rtc_pkg::CapCsma]) bc_d = '0;
            if (!cfg_i.radio_offload[csma_rtc_pkg::CapRetries]) rc_d = '0;
            go_start = 1'b1;
          end
        end
        csma_rtc_pkg::REQ_STARTED: begin
          if (!cfg_i.radio_offload[csma_rtc_pkg::CapAckTimeout] && item_i.ack_requested) begin
            purp_a = csma_rtc_pkg::PURP_ACK;
            cnt_a  = TIMER_BITS'(cfg_i.ack_timeout_ticks);
          end
        end
        csma_rtc_pkg::REQ_DONE: begin
          do_done = 1'b1;
          err     = item_i.radio_status;
        end
        csma_rtc_pkg::REQ_TICK: begin
          if (purp_q == csma_rtc_pkg::PURP_ACK || purp_q == csma_rtc_pkg::PURP_CSMA) begin
            cnt_a = cnt_dec;
            if (cnt_dec == '0) begin
              purp_a = csma_rtc_pkg::PURP_NONE;
              if (purp_q == csma_rtc_pkg::PURP_ACK) begin
                do_done = 1'b1;
                err     = csma_rtc_pkg::RstNoAck;
                resume  = 1'b1;
              end else begin
                act_a = csma_rtc_pkg::ACT_START;
              end
            end
          end
        end
        default: ;
      endcase
    end
    // transmit result handling, shared by radio result and ack timeout
    if (do_done) begin
      if (!cfg_i.radio_offload[csma_rtc_pkg::CapAckTimeout]) begin
        purp_a = csma_rtc_pkg::PURP_NONE;
        cnt_a  = '0;
      end
      if (!cfg_i.radio_offload[csma_rtc_pkg::CapCsma]) begin
        if (err == csma_rtc_pkg::RstCaf) begin
          if (bc_d < csma_rtc_pkg::CntMax) bc_d = bc_d + 4'd1;
          if (bc_d < fmb_d) restart = 1'b1;
        end else begin
          bc_d = '0;
        end
      end
      if (!restart && !cfg_i.radio_offload[csma_rtc_pkg::CapRetries]
          && err != csma_rtc_pkg::RstOk && rc_d < fmr_d) begin
        rc_d = rc_d + 4'd1;
        if (cfg_i.csma_off_last_try && fmr_d != '0 && fmr_d <= rc_d) csma_d = 1'b0;
        restart = 1'b1;
      end
      if (restart) begin
        go_start = 1'b1;
      end else begin
        resume = 1'b1;
        act_a  = csma_rtc_pkg::ACT_REPORT;
        st     = (err > csma_rtc_pkg::RstAbort) ? csma_rtc_pkg::ST_ABORT
                                                : csma_rtc_pkg::status_e'(err[1:0]);
      end
    end
  end

  csma_rtc_backoff #(
    .TIMER_BITS(TIMER_BITS)
  ) u_backoff (
    .min_be_i       (cfg_i.min_be),
    .max_be_i       (cfg_i.max_be),
    .unit_ticks_i   (cfg_i.backoff_unit_ticks),
    .retry_count_i  (rc_d),
    .backoff_count_i(bc_d),
    .random_draw_i  (item_i.random_draw),
    .ticks_o        (bo_ticks)
  );

  // transmit start: backoff first unless the radio does csma itself or csma is off for this try
  always_comb begin
    act    = act_a;
    purp_d = purp_a;
    cnt_d  = cnt_a;
    if (go_start) begin
      if (!cfg_i.radio_offload[csma_rtc_pkg::CapCsma] && csma_d) begin
        purp_d = csma_rtc_pkg::PURP_CSMA;
        cnt_d  = bo_ticks;
        act    = csma_rtc_pkg::ACT_NONE;
      end else begin
        act = csma_rtc_pkg::ACT_START;
      end
    end
    result_o.valid          = step_i && (act != csma_rtc_pkg::ACT_NONE || resume);
    result_o.action         = act;
    result_o.done_status    = (act == csma_rtc_pkg::ACT_REPORT) ? st : csma_rtc_pkg::ST_OK;
    result_o.use_csma       = (act == csma_rtc_pkg::ACT_START) ? csma_d : 1'b0;
    result_o.resume_receive = resume;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q   <= '0;
      bc_q   <= '0;
      fmb_q  <= '0;
      fmr_q  <= '0;
      csma_q <= 1'b1;
      cnt_q  <= '0;
      purp_q <= csma_rtc_pkg::PURP_NONE;
    end else begin
      rc_q   <= rc_d;
      bc_q   <= bc_d;
      fmb_q  <= fmb_d;
      fmr_q  <= fmr_d;
      csma_q <= csma_d;
      cnt_q  <= cnt_d;
      purp_q <= purp_d;
    end
  end

`ifndef NO_ASSERTIONS
  // an idle timer is always cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    purp_q == csma_rtc_pkg::PURP_NONE |-> cnt_q == '0)
    else $error("idle timer holds a count");

  // backoff counter only steps by one or clears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bc_q != $past(bc_q) |-> (bc_q == '0 || bc_q == $past(bc_q) + 4'd1))
    else $error("backoff counter jumped");

  // csma is only dropped on a retry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(csma_q) |-> rc_q != '0)
    else $error("csma cleared without a retry");
`endif

endmodule
